@@ hdl/kcd_pkg.sv @@
// kcd_pkg: shared constants, item layouts and codes of the key chord detector.
// No dependencies; compile first.
`timescale 1ns / 1ps

package kcd_pkg;

  // Parameter defaults
  localparam int MAX_COMBOS_DEF     = 32;
  localparam int KEYS_PER_COMBO_DEF = 5;
  localparam int KEY_CODE_BITS_DEF  = 16;

  // Field widths of the items
  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 16;
  localparam int CIDX_W   = 5;
  localparam int SIDX_W   = 3;
  localparam int CFG_W    = 6;

  // Pressed bitmap row layout: 32 key bits per row
  localparam int MAP_COL_BITS = 5;
  localparam int MAP_ROW_BITS = 1 << MAP_COL_BITS;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_PRESS   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd2;

  // Chord event codes
  localparam logic EVT_COMPLETE = 1'b0;
  localparam logic EVT_BROKEN   = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key_code;
    logic [CIDX_W-1:0] combo_index;
    logic [SIDX_W-1:0] slot_index;
    logic              slot_valid;
  } cmd_t;

  typedef struct packed {
    logic [CIDX_W-1:0] matched_combo;
    logic              chord_event;
    logic              last_in_run;
  } res_t;

endpackage

@@ hdl/kcd_ifs.sv @@
// kcd channel interfaces: command items in, result items out, register write.
// Depends on kcd_pkg.
`timescale 1ns / 1ps

interface kcd_cmd_if import kcd_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kcd_res_if import kcd_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kcd_cfg_if import kcd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/kcd_keymap.sv @@
// kcd_keymap: pressed-key bitmap memory, 32 keys per row, with a clearing
// sweep after reset. Depends on kcd_pkg.
`timescale 1ns / 1ps

module kcd_keymap import kcd_pkg::*; #(
  parameter int KEY_CODE_BITS = KEY_CODE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic [KEY_CODE_BITS-MAP_COL_BITS-1:0]   rd_addr,
  output logic [MAP_ROW_BITS-1:0]                 rd_row,
  input  logic                                    wr_en,
  input  logic [KEY_CODE_BITS-MAP_COL_BITS-1:0]   wr_addr,
  input  logic [MAP_ROW_BITS-1:0]                 wr_row,
  output logic                                    busy
);

  localparam int ROW_W = KEY_CODE_BITS - MAP_COL_BITS;
  localparam int ROWS  = 1 << ROW_W;

  logic [MAP_ROW_BITS-1:0] mem [ROWS];
  logic [ROW_W-1:0]        clr_addr;

  // Sweep every row once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    rd_row <= mem[rd_addr];
  end

endmodule

@@ hdl/key_chord_detector_unit.sv @@
// key_chord_detector_unit: top level of the key chord detector.
// Depends on kcd_pkg, kcd_ifs (channel interfaces) and kcd_keymap.
`timescale 1ns / 1ps

// Channel  Role    Carries                                            Accept
// -------  ------  -------------------------------------------------  ---------------
// cmd      sink    func, key_code, combo_index, slot_index, slot_valid valid & ready
// res      source  matched_combo, chord_event, last_in_run             valid & ready
// cfg      sink    combos_in_use (6 bits)                              valid & ready
//
// A slot load item or an unused func code is finished on accept. A key item
// does one read-modify-write of the bitmap row and, with n =
// min(combos_in_use, MAX_COMBOS) > 0, walks every slot of the n combos, each
// slot taking a slot memory read and a bitmap read, plus one decision step
// per combo; when n is 0 only the row update is done.
// After reset the bitmap is swept clear, all 2**(KEY_CODE_BITS-5) rows,
// while cmd is held not ready; cfg is always ready.
// A full result register stalls the sequencer; cmd stays not ready meanwhile.

module key_chord_detector_unit import kcd_pkg::*; #(
  parameter int MAX_COMBOS     = MAX_COMBOS_DEF,
  parameter int KEYS_PER_COMBO = KEYS_PER_COMBO_DEF,
  parameter int KEY_CODE_BITS  = KEY_CODE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  kcd_cfg_if.sink   cfg,
  kcd_cmd_if.sink   cmd,
  kcd_res_if.source res
);

  localparam int NUM_SLOTS = MAX_COMBOS * KEYS_PER_COMBO;
  localparam int SA_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SW    = (KEYS_PER_COMBO > 1) ? $clog2(KEYS_PER_COMBO) : 1;
  localparam int CW    = (MAX_COMBOS > 1) ? $clog2(MAX_COMBOS) : 1;
  localparam int NW    = $clog2(MAX_COMBOS + 1);
  localparam int MW    = $clog2(KEYS_PER_COMBO + 1);
  localparam int ROW_W = KEY_CODE_BITS - MAP_COL_BITS;
  localparam int NCMP  = (CFG_W > NW) ? CFG_W : NW;

  typedef enum logic [7:0] {
    ST_CLEAR     = 8'b0000_0001,
    ST_IDLE      = 8'b0000_0010,
    ST_UPD       = 8'b0000_0100,
    ST_SLOT_WAIT = 8'b0000_1000,
    ST_KEY       = 8'b0001_0000,
    ST_EVAL      = 8'b0010_0000,
    ST_DECIDE    = 8'b0100_0000,
    ST_FLUSH     = 8'b1000_0000
  } state_t;

  state_t state;

  // Configuration register
  logic [CFG_W-1:0] combos_in_use;

  // Event being processed
  logic [KEY_CODE_BITS-1:0] ev_key;
  logic                     ev_press;
  logic [NW-1:0]            n_q;
  logic [NW-1:0]            n_eff;

  // Combo table: keys in memory, valid bits in flops
  logic [KEY_CODE_BITS-1:0] slot_mem [NUM_SLOTS];
  logic [KEY_CODE_BITS-1:0] slot_q;
  logic [NUM_SLOTS-1:0]     slot_vld;
  logic [SA_W-1:0]          slot_addr;
  logic                     load_we;
  logic [SA_W-1:0]          load_addr;

  // Walk counters and per-combo scratch
  logic [CW-1:0]            combo;
  logic [SW-1:0]            slot;
  logic [MW-1:0]            missing;
  logic                     contains;
  logic                     eff_q;
  logic [MAP_COL_BITS-1:0]  cur_col;
  logic [KEY_CODE_BITS-1:0] kk [KEYS_PER_COMBO];
  logic [KEYS_PER_COMBO-1:0] kv;
  logic                     dup;
  logic                     eff_now;
  logic                     hit;

  // Pending result and output register
  logic                     pend_v;
  logic [CW-1:0]            pend_c;
  logic                     pend_evt;
  res_t                     res_q;
  logic                     res_v;
  logic                     out_free;
  logic                     res_load;

  // Bitmap port
  logic [ROW_W-1:0]         map_rd_addr;
  logic [MAP_ROW_BITS-1:0]  map_q;
  logic                     map_we;
  logic [MAP_ROW_BITS-1:0]  map_wr_row;
  logic [MAP_ROW_BITS-1:0]  bit_sel;
  logic                     map_busy;
  logic                     cmd_acc;

  kcd_keymap #(
    .KEY_CODE_BITS (KEY_CODE_BITS)
  ) u_keymap (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (map_rd_addr),
    .rd_row  (map_q),
    .wr_en   (map_we),
    .wr_addr (ev_key[KEY_CODE_BITS-1:MAP_COL_BITS]),
    .wr_row  (map_wr_row),
    .busy    (map_busy)
  );

  assign cfg.ready = 1'b1;
  assign cmd.ready = (state == ST_IDLE);
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign res.valid = res_v;
  assign res.data  = res_q;
  assign out_free  = !res_v || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      combos_in_use <= '0;
    end else if (cfg.valid) begin
      combos_in_use <= cfg.data;
    end
  end

  // Clamp the combo count to the table size
  always_comb begin
    if (NCMP'(combos_in_use) > NCMP'(MAX_COMBOS)) begin
      n_eff = NW'(MAX_COMBOS);
    end else begin
      n_eff = NW'(combos_in_use);
    end
  end

  // Slot loads: ignore out-of-range combo or slot
  assign load_we   = cmd_acc && (cmd.data.func == FUNC_LOAD) &&
                     (int'(cmd.data.combo_index) < MAX_COMBOS) &&
                     (int'(cmd.data.slot_index) < KEYS_PER_COMBO);
  assign load_addr = SA_W'(int'(cmd.data.combo_index) * KEYS_PER_COMBO +
                           int'(cmd.data.slot_index));

  always_ff @(posedge clk) begin
    if (load_we) begin
      slot_mem[load_addr] <= cmd.data.key_code[KEY_CODE_BITS-1:0];
    end
    slot_q <= slot_mem[slot_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
    end else if (load_we) begin
      slot_vld[load_addr] <= cmd.data.slot_valid;
    end
  end

  // A slot counts only once per combo: drop it if an earlier valid slot
  // holds the same key
  always_comb begin
    dup = 1'b0;
    for (int t = 0; t < KEYS_PER_COMBO; t++) begin
      if ((SW'(t) < slot) && kv[t] && (kk[t] == slot_q)) begin
        dup = 1'b1;
      end
    end
    eff_now = slot_vld[slot_addr] && !dup;
  end

  // Bitmap read: event key on accept, slot key during the walk
  assign map_rd_addr = (state == ST_KEY) ? slot_q[KEY_CODE_BITS-1:MAP_COL_BITS]
                                         : cmd.data.key_code[KEY_CODE_BITS-1:MAP_COL_BITS];
  assign bit_sel     = MAP_ROW_BITS'(1) << ev_key[MAP_COL_BITS-1:0];
  assign map_we      = (state == ST_UPD);
  assign map_wr_row  = ev_press ? (map_q | bit_sel) : (map_q & ~bit_sel);

  // Press completes with nothing missing; release breaks with one missing
  assign hit = contains && (ev_press ? (missing == '0) : (missing == MW'(1)));

  // Load the output register when an earlier hit moves out or the last one
  // is flushed
  assign res_load = ((state == ST_DECIDE) && hit && pend_v && out_free) ||
                    ((state == ST_FLUSH) && pend_v && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      pend_v <= 1'b0;
      res_v  <= 1'b0;
    end else begin
      if (res_load) begin
        res_v <= 1'b1;
      end else if (res.ready) begin
        res_v <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (!map_busy) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_acc && (cmd.data.func inside {FUNC_PRESS, FUNC_RELEASE})) begin
            ev_key   <= cmd.data.key_code[KEY_CODE_BITS-1:0];
            ev_press <= (cmd.data.func == FUNC_PRESS);
            state    <= ST_UPD;
          end
        end
        ST_UPD: begin
          // Bitmap row is written this cycle; start the walk at slot zero
          n_q       <= n_eff;
          combo     <= '0;
          slot      <= '0;
          slot_addr <= '0;
          missing   <= '0;
          contains  <= 1'b0;
          kv        <= '0;
          state     <= (n_eff == '0) ? ST_IDLE : ST_SLOT_WAIT;
        end
        ST_SLOT_WAIT: begin
          state <= ST_KEY;
        end
        ST_KEY: begin
          kk[slot]  <= slot_q;
          kv[slot]  <= slot_vld[slot_addr];
          cur_col   <= slot_q[MAP_COL_BITS-1:0];
          eff_q     <= eff_now;
          if (eff_now && (slot_q == ev_key)) begin
            contains <= 1'b1;
          end
          slot_addr <= slot_addr + 1'b1;
          state     <= ST_EVAL;
        end
        ST_EVAL: begin
          if (eff_q && !map_q[cur_col]) begin
            missing <= missing + 1'b1;
          end
          if (slot == SW'(KEYS_PER_COMBO - 1)) begin
            state <= ST_DECIDE;
          end else begin
            slot  <= slot + 1'b1;
            state <= ST_KEY;
          end
        end
        ST_DECIDE: begin
          // Hold while an earlier hit must move out and the output is full
          if (!(hit && pend_v && !out_free)) begin
            if (hit) begin
              if (pend_v) begin
                res_q.matched_combo  <= CIDX_W'(pend_c);
                res_q.chord_event    <= pend_evt;
                res_q.last_in_run    <= 1'b0;
              end
              pend_v   <= 1'b1;
              pend_c   <= combo;
              pend_evt <= ev_press ? EVT_COMPLETE : EVT_BROKEN;
            end
            slot     <= '0;
            missing  <= '0;
            contains <= 1'b0;
            kv       <= '0;
            if (NW'(combo) + 1'b1 == n_q) begin
              state <= ST_FLUSH;
            end else begin
              combo <= combo + 1'b1;
              state <= ST_KEY;
            end
          end
        end
        ST_FLUSH: begin
          // Last hit of the run carries the end mark
          if (!pend_v) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            res_q.matched_combo <= CIDX_W'(pend_c);
            res_q.chord_event   <= pend_evt;
            res_q.last_in_run   <= 1'b1;
            pend_v              <= 1'b0;
            state               <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
